FILE: src/aalu_pkg.sv
// Shared types and constants for the ARM data-processing ALU.
// Holds the opcode enum, flag bit positions and the request/response beat layouts.
// No dependencies.
package aalu_pkg;

   localparam int DATA_W   = 32;
   localparam int FLAGS_W  = 4;
   localparam int REQ_BITS = 69;   // op + two operands + carry + S bit
   localparam int REQ_W    = 72;   // padded to whole bytes
   localparam int RSP_BITS = 37;   // result + writes_result + flags
   localparam int RSP_W    = 40;

   // NZCV bit positions
   localparam int FLAG_N = 3;
   localparam int FLAG_Z = 2;
   localparam int FLAG_C = 1;
   localparam int FLAG_V = 0;

   typedef enum logic [2:0] {
      OP_ADC = 3'd0,
      OP_SBC = 3'd1,
      OP_EOR = 3'd2,
      OP_TEQ = 3'd3,
      OP_CMP = 3'd4,
      OP_CMN = 3'd5,
      OP_RSC = 3'd6,
      OP_BIC = 3'd7
   } op_type;

   // packed MSB first, so op lands in the lowest bits
   typedef struct packed {
      logic              set_flags;
      logic              carry_bit;
      logic [DATA_W-1:0] right_operand;
      logic [DATA_W-1:0] left_operand;
      op_type            op;
   } request_type;

   typedef struct packed {
      logic [FLAGS_W-1:0] flags;
      logic               writes_result;
      logic [DATA_W-1:0]  result;
   } response_type;

endpackage

FILE: src/aalu_core.sv
// Combinational datapath: one shared 33-bit adder, logic unit and NZCV update.
// Depends on aalu_pkg.
module aalu_core
   import aalu_pkg::*;
(
   input  request_type        req,
   input  logic [FLAGS_W-1:0] nzcv_cur,
   output response_type       rsp
);

   logic [DATA_W-1:0]  add_a;
   logic [DATA_W-1:0]  add_b;
   logic               add_cin;
   logic [DATA_W:0]    add_sum;
   logic [DATA_W-1:0]  sum;
   logic [DATA_W-1:0]  logic_res;
   logic [FLAGS_W-1:0] arith_flags;
   logic [FLAGS_W-1:0] logic_flags;

   // operand steering for the single adder; subtracts are a + ~b + cin
   always_comb begin
      add_a   = req.left_operand;
      add_b   = req.right_operand;
      add_cin = req.carry_bit;
      case (req.op)
         OP_SBC: add_b = ~req.right_operand;
         OP_CMP: begin
            add_b   = ~req.right_operand;
            add_cin = 1'b1;
         end
         OP_CMN: add_cin = 1'b0;
         OP_RSC: begin
            add_a = req.right_operand;
            add_b = ~req.left_operand;
         end
         default: ;
      endcase
   end

   assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{DATA_W{1'b0}}, add_cin};
   assign sum     = add_sum[DATA_W-1:0];

   assign logic_res = (req.op == OP_BIC) ? (req.left_operand & ~req.right_operand)
                                         : (req.left_operand ^ req.right_operand);

   always_comb begin
      arith_flags         = '0;
      arith_flags[FLAG_N] = sum[DATA_W-1];
      arith_flags[FLAG_Z] = (sum == '0);
      arith_flags[FLAG_C] = add_sum[DATA_W];
      arith_flags[FLAG_V] = ~(add_a[DATA_W-1] ^ add_b[DATA_W-1])
                            & (add_a[DATA_W-1] ^ sum[DATA_W-1]);
      // logical ops touch N and Z only
      logic_flags         = nzcv_cur;
      logic_flags[FLAG_N] = logic_res[DATA_W-1];
      logic_flags[FLAG_Z] = (logic_res == '0);
   end

   always_comb begin
      rsp.result        = '0;
      rsp.writes_result = 1'b1;
      rsp.flags         = nzcv_cur;
      unique case (req.op)
         OP_ADC, OP_SBC, OP_RSC: begin
            rsp.result = sum;
            if (req.set_flags) rsp.flags = arith_flags;
         end
         OP_EOR, OP_BIC: begin
            rsp.result = logic_res;
            if (req.set_flags) rsp.flags = logic_flags;
         end
         OP_TEQ: begin
            rsp.writes_result = 1'b0;
            rsp.flags         = logic_flags;
         end
         OP_CMP, OP_CMN: begin
            rsp.writes_result = 1'b0;
            rsp.flags         = arith_flags;
         end
         default: ;
      endcase
   end

endmodule

FILE: src/arm_alu_with_flags.sv
// An accepted req beat passes through the input register and then the result register to its rsp beat.
// Throughput: one beat per cycle unless the rsp side stalls; the flag register updates in the same cycle the result
// is captured, so the next item in the input register already sees the new NZCV.
// Reset (synchronous, active high) clears both valid bits and the NZCV register to zero.
// Depends on aalu_pkg and aalu_core.
module arm_alu_with_flags
   import aalu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // req_tdata, low bit up: op[2:0], left_operand[31:0], right_operand[31:0],
   // carry_bit, set_flags, 3 zero pad bits
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   // rsp_tdata, low bit up: result[31:0], writes_result, flags[3:0] (NZCV), 3 zero pad bits
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   // input register
   logic               in_vld_ff, in_vld_in;
   request_type        in_ff;
   // result register
   logic               out_vld_ff, out_vld_in;
   response_type       out_ff;
   // architectural flags
   logic [FLAGS_W-1:0] nzcv_ff, nzcv_in;

   response_type       core_rsp;
   logic               out_free;
   logic               advance;
   logic               req_beat;

   // result slot is free when empty or being drained this cycle
   assign out_free   = !out_vld_ff || rsp_tready;
   assign advance    = in_vld_ff && out_free;
   // input slot takes a beat when empty or moving on this cycle
   assign req_tready = !in_vld_ff || out_free;
   assign req_beat   = req_tvalid && req_tready;

   aalu_core u_core (
      .req      (in_ff),
      .nzcv_cur (nzcv_ff),
      .rsp      (core_rsp)
   );

   always_comb begin
      in_vld_in  = req_beat || (in_vld_ff && !out_free);
      out_vld_in = advance || (out_vld_ff && !rsp_tready);
      nzcv_in    = advance ? core_rsp.flags : nzcv_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         nzcv_ff    <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         nzcv_ff    <= nzcv_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_ff <= request_type'(req_tdata[REQ_BITS-1:0]);
      end
      if (advance) begin
         out_ff <= core_rsp;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(RSP_W-RSP_BITS){1'b0}}, out_ff};

   // flags shown with a result always equal the flag register after that item
   a_flags_track: assert property (@(posedge clock) disable iff (reset)
      advance |=> (nzcv_ff == out_ff.flags))
      else $error("flag register and captured flags differ");

   // flags move only when an item leaves the input register
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(nzcv_ff))
      else $error("flag register changed without an item");

   // logical ops never touch C and V
   a_logic_cv: assert property (@(posedge clock) disable iff (reset)
      advance && (in_ff.op == OP_EOR || in_ff.op == OP_BIC || in_ff.op == OP_TEQ)
      |=> (nzcv_ff[FLAG_C:FLAG_V] == $past(nzcv_ff[FLAG_C:FLAG_V])))
      else $error("logical op altered C or V");

   // compares produce no destination write and a zero result
   a_cmp_nowrite: assert property (@(posedge clock) disable iff (reset)
      advance && (in_ff.op == OP_TEQ || in_ff.op == OP_CMP || in_ff.op == OP_CMN)
      |=> (!out_ff.writes_result && (out_ff.result == '0)))
      else $error("compare wrote a result");

   // a stalled result is never overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_tready |-> !advance)
      else $error("result register overwritten while stalled");

endmodule

FILE: sim/arm_alu_with_flags_tb.sv
// Self-checking testbench for arm_alu_with_flags: directed and random ALU beats,
// checked against an in-bench NZCV model with random idling on both stream sides.
// Depends on aalu_pkg and the arm_alu_with_flags RTL.
module arm_alu_with_flags_tb;
   import aalu_pkg::*;

   localparam int RANDOM_BEATS = 1080;
   localparam int CALM_FIRST   = 500;   // cycle window with no idling on either side
   localparam int CALM_LAST    = 900;
   localparam int SETTLE_TICKS = 8;     // margin after the last beat for stray responses

   // one queued stimulus beat; hold makes the driver wait until nothing is in flight
   typedef struct {
      request_type rq;
      bit          hold;
   } stim_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   stim_type     req_backlog[$];   // beats not yet offered to the DUT
   response_type awaited_rsp[$];   // predicted responses, oldest first
   logic [3:0]   nzcv_model = '0;  // model copy of the flag register
   int           beats_in   = 0;   // accepted req beats (updated by the monitor only)
   int           beats_out  = 0;   // accepted rsp beats (updated by the monitor only)
   int           tick       = 0;
   int           mismatches = 0;
   int           op_seen[8];

   arm_alu_with_flags i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #4000000;
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      tick <= tick + 1;
   end

   // ---------------------------------------------------------------------------
   // Model
   // ---------------------------------------------------------------------------

   // 32-bit add with carry in; returns NZCV, C is carry out, V is signed overflow
   function automatic logic [3:0] add_nzcv(input logic [31:0] a, input logic [31:0] b,
                                           input logic cin, output logic [31:0] sum);
      logic [32:0] wide;
      logic        ovf;
      wide = {1'b0, a} + {1'b0, b} + {32'd0, cin};
      sum  = wide[31:0];
      ovf  = ~(a[31] ^ b[31]) & (a[31] ^ sum[31]);
      return {sum[31], sum == '0, wide[32], ovf};
   endfunction

   // logical ops: fresh N and Z, held C and V (no shifter carry-out)
   function automatic logic [3:0] logic_nzcv(input logic [31:0] val);
      return {val[31], val == '0, nzcv_model[FLAG_C], nzcv_model[FLAG_V]};
   endfunction

   // expected response for one accepted beat; advances the flag model
   function automatic response_type alu_outcome(input request_type rq);
      response_type rs;
      logic [31:0]  scratch;
      logic [3:0]   f;
      rs.result        = '0;
      rs.writes_result = 1'b1;
      case (rq.op)
         OP_ADC: begin
            f = add_nzcv(rq.left_operand, rq.right_operand, rq.carry_bit, rs.result);
            if (rq.set_flags) nzcv_model = f;
         end
         OP_SBC: begin
            f = add_nzcv(rq.left_operand, ~rq.right_operand, rq.carry_bit, rs.result);
            if (rq.set_flags) nzcv_model = f;
         end
         OP_RSC: begin
            f = add_nzcv(rq.right_operand, ~rq.left_operand, rq.carry_bit, rs.result);
            if (rq.set_flags) nzcv_model = f;
         end
         OP_EOR: begin
            rs.result = rq.left_operand ^ rq.right_operand;
            if (rq.set_flags) nzcv_model = logic_nzcv(rs.result);
         end
         OP_BIC: begin
            rs.result = rq.left_operand & ~rq.right_operand;
            if (rq.set_flags) nzcv_model = logic_nzcv(rs.result);
         end
         OP_TEQ: begin
            nzcv_model       = logic_nzcv(rq.left_operand ^ rq.right_operand);
            rs.writes_result = 1'b0;
         end
         OP_CMP: begin
            // carry bit is ignored: always L + ~R + 1
            nzcv_model       = add_nzcv(rq.left_operand, ~rq.right_operand, 1'b1, scratch);
            rs.writes_result = 1'b0;
         end
         default: begin   // OP_CMN
            nzcv_model       = add_nzcv(rq.left_operand, rq.right_operand, 1'b0, scratch);
            rs.writes_result = 1'b0;
         end
      endcase
      rs.flags = nzcv_model;
      return rs;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // ~9% idle per side, none inside the calm window
   function automatic bit take_break();
      return (tick < CALM_FIRST || tick > CALM_LAST) && $urandom_range(99) < 9;
   endfunction

   // operand values biased toward the corners that move the flags
   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return 32'h0000_0001;
         5:       return 32'($urandom_range(15));
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_beat(input op_type op, input logic [31:0] lhs, input logic [31:0] rhs,
                             input logic cin, input logic sbit, input bit hold);
      stim_type st;
      st.rq.op            = op;
      st.rq.left_operand  = lhs;
      st.rq.right_operand = rhs;
      st.rq.carry_bit     = cin;
      st.rq.set_flags     = sbit;
      st.hold             = hold;
      req_backlog.push_back(st);
   endtask

   // ---------------------------------------------------------------------------
   // Driver: offers backlog beats, holds tvalid/tdata steady under backpressure
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      logic sent_now;
      logic launch;
      int   in_flight;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         sent_now = req_tvalid && req_tready;
         if (!req_tvalid || req_tready) begin
            // beats_in/out are last edge's values; count this edge's send by hand
            in_flight = beats_in + int'(sent_now) - beats_out;
            launch    = req_backlog.size() != 0 && !take_break();
            if (launch && req_backlog[0].hold && in_flight != 0) begin
               launch = 1'b0;
            end
            if (launch) begin
               req_tdata <= {{(REQ_W-REQ_BITS){1'b0}}, req_backlog[0].rq};
               void'(req_backlog.pop_front());
            end
            req_tvalid <= launch;
         end
      end
   end

   // response side backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !take_break();
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: checks rsp beats first, then predicts the req beat of this edge.
   // Each req passes the input and the result register, so a same-edge rsp can never belong to that req.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : watch_beats
      request_type  rq;
      response_type got;
      response_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got        = response_type'(rsp_tdata[RSP_BITS-1:0]);
            beats_out <= beats_out + 1;
            if (awaited_rsp.size() == 0) begin
               $error("rsp beat with nothing outstanding: result %h flags %b",
                      got.result, got.flags);
               mismatches++;
            end else begin
               want = awaited_rsp.pop_front();
               if (got.result !== want.result) begin
                  $error("result: expected %h, got %h", want.result, got.result);
                  mismatches++;
               end
               if (got.writes_result !== want.writes_result) begin
                  $error("writes_result: expected %b, got %b",
                         want.writes_result, got.writes_result);
                  mismatches++;
               end
               if (got.flags !== want.flags) begin
                  $error("flags: expected %b, got %b", want.flags, got.flags);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            rq = request_type'(req_tdata[REQ_BITS-1:0]);
            awaited_rsp.push_back(alu_outcome(rq));
            beats_in <= beats_in + 1;
            op_seen[int'(rq.op)]++;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------------
   initial begin : main_seq
      op_type      op;
      logic [31:0] lhs;
      logic [31:0] rhs;
      foreach (op_seen[k]) op_seen[k] = 0;

      // directed corners
      queue_beat(OP_ADC, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 0); // carry out, zero
      queue_beat(OP_ADC, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 1'b1, 0); // signed overflow
      queue_beat(OP_ADC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 0); // S clear: flags held
      queue_beat(OP_SBC, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 0); // borrow via NOT carry
      queue_beat(OP_SBC, 32'h8000_0000, 32'h0000_0001, 1'b1, 1'b1, 0); // overflow
      queue_beat(OP_SBC, 32'h0000_0005, 32'h0000_0005, 1'b1, 1'b1, 0); // zero, no borrow
      queue_beat(OP_EOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 0); // zero, C/V kept
      queue_beat(OP_EOR, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 0); // no flag write
      queue_beat(OP_TEQ, 32'h1234_5678, 32'h1234_5678, 1'b1, 1'b0, 0); // equal, S ignored
      queue_beat(OP_TEQ, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b1, 0); // negative
      queue_beat(OP_CMP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 0); // equal, carry bit 0
      queue_beat(OP_CMP, 32'h0000_0000, 32'h0000_0001, 1'b1, 1'b0, 0); // borrow
      queue_beat(OP_CMP, 32'h8000_0000, 32'h0000_0001, 1'b1, 1'b1, 0); // overflow
      queue_beat(OP_CMN, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b0, 0); // carry, zero
      queue_beat(OP_CMN, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 1'b1, 0); // overflow
      queue_beat(OP_RSC, 32'h0000_0001, 32'h0000_0003, 1'b1, 1'b1, 0); // R - L
      queue_beat(OP_RSC, 32'h0000_0001, 32'h8000_0000, 1'b1, 1'b1, 0); // overflow
      queue_beat(OP_RSC, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 0); // minus one, held
      queue_beat(OP_BIC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 0); // zero
      queue_beat(OP_BIC, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 0); // negative
      queue_beat(OP_BIC, 32'h0F0F_0F0F, 32'h00FF_00FF, 1'b0, 1'b0, 0); // no flag write

      // random part; the first beat and a few more wait for a drained pipe
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         op  = op_type'($urandom_range(7));
         lhs = pick_word();
         case ($urandom_range(7))
            0:       rhs = lhs;    // Z on CMP, TEQ, EOR, BIC, and on SBC/RSC with carry set
            1:       rhs = ~lhs;
            default: rhs = pick_word();
         endcase
         queue_beat(op, lhs, rhs, 1'($urandom_range(1)), 1'($urandom_range(1)),
                    n == 0 || $urandom_range(149) == 0);
      end

      // judged at the falling edge so the driver's NBAs are settled
      @(negedge reset);
      do begin
         @(negedge clock);
      end while (req_backlog.size() != 0 || req_tvalid || beats_in != beats_out);
      repeat (SETTLE_TICKS) @(negedge clock);

      if (awaited_rsp.size() != 0) begin
         $error("%0d expected rsp beats never arrived", awaited_rsp.size());
         mismatches++;
      end

      $display("covered %0d req beats, %0d rsp beats, %0d mismatches",
               beats_in, beats_out, mismatches);
      $display("per op: adc %0d sbc %0d eor %0d teq %0d cmp %0d cmn %0d rsc %0d bic %0d",
               op_seen[OP_ADC], op_seen[OP_SBC], op_seen[OP_EOR], op_seen[OP_TEQ],
               op_seen[OP_CMP], op_seen[OP_CMN], op_seen[OP_RSC], op_seen[OP_BIC]);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
src/aalu_pkg.sv
src/aalu_core.sv
src/arm_alu_with_flags.sv
sim/arm_alu_with_flags_tb.sv
